[src/stx_etx_hex_sum_deframer_macros.svh]
// ----------------------------------------------------------------------------
// STX/ETX deframer assertion macros
// Concurrent checks on clock, disabled in reset; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef STX_ETX_HEX_SUM_DEFRAMER_MACROS_SVH
`define STX_ETX_HEX_SUM_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
// check a condition at every clock edge
`define SEHD_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// check a condition in the cycle after a trigger
`define SEHD_ASSERT_NEXT(label, trig, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error(msg);
`else
`define SEHD_ASSERT(label, expr, msg)
`define SEHD_ASSERT_NEXT(label, trig, expr, msg)
`endif
`endif

[src/sehd_pkg.sv]
// ----------------------------------------------------------------------------
// STX/ETX deframer package
// Byte codes, status codes, transaction payload types and hex encoding.
// ----------------------------------------------------------------------------
package sehd_pkg;

   // default longest frame in bytes
   localparam int MAX_FRAME_DEFAULT = 256;

   // framing bytes
   localparam logic [7:0] BYTE_STX = 8'h02;
   localparam logic [7:0] BYTE_ETX = 8'h03;
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_LF  = 8'h0A;

   // ASCII offsets for hex digits
   localparam logic [7:0] HEX_DIGIT_BASE  = 8'h30;
   localparam logic [7:0] HEX_LETTER_BASE = 8'h37;

   // largest reported payload count
   localparam logic [7:0] COUNT_MAX = 8'hFF;

   // frame position at which payload bytes begin to leave the delay window
   localparam int FRAME_OVERHEAD = 6;
   // number of slots in the delay window
   localparam int WINDOW_DEPTH = 5;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_ACK        = 3'd1,
      STATUS_NAK        = 3'd2,
      STATUS_INCOMPLETE = 3'd3,
      STATUS_HEADER     = 3'd4,
      STATUS_CHECKSUM   = 3'd5,
      STATUS_LONG       = 3'd6
   } sehd_status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } sehd_req_type;

   typedef struct packed {
      logic       frame_end;
      logic [7:0] payload_byte;
      logic [7:0] command_byte;
      logic [2:0] frame_status;
      logic [7:0] payload_count;
   } sehd_rsp_type;

   // per-frame flags
   typedef struct packed {
      logic stx_seen;
      logic etx_seen;
      logic prev_cr;
      logic overflow;
   } sehd_flags_type;

   // uppercase ASCII hex character of a nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      hex_char = (nib < 4'd10) ? wide + HEX_DIGIT_BASE : wide + HEX_LETTER_BASE;
   endfunction

endpackage

[src/sehd_stream_if.sv]
// ----------------------------------------------------------------------------
// STX/ETX deframer stream channel
// Valid/ready channel; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface sehd_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[src/sehd_in_stage.sv]
// ----------------------------------------------------------------------------
// STX/ETX deframer input register
// Holds one received byte until the core consumes it.
// ----------------------------------------------------------------------------
module sehd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       load;

   // take a new transaction when empty or when the held byte moves on
   assign req_ready = !valid_ff || advance;
   assign load      = req_valid && req_ready;
   assign valid_in  = load ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // capture payload
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

[src/sehd_core.sv]
// ----------------------------------------------------------------------------
// STX/ETX deframer core
// Frame state, delay window, running sum and the result of one byte.
// ----------------------------------------------------------------------------
`include "stx_etx_hex_sum_deframer_macros.svh"

module sehd_core #(
   parameter int MAX_FRAME = sehd_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   output logic                 res_valid,
   output sehd_pkg::sehd_rsp_type res
);

   localparam int POS_W = $clog2(MAX_FRAME + 1);
   localparam int DIFF_W = POS_W + 8;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME);
   localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
   localparam logic [POS_W-1:0] POS_SUM_START = POS_W'(sehd_pkg::WINDOW_DEPTH - 1);
   localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(sehd_pkg::FRAME_OVERHEAD);
   localparam int LAST = sehd_pkg::WINDOW_DEPTH - 1;

   logic [7:0]               win_ff [sehd_pkg::WINDOW_DEPTH];
   logic [7:0]               win_in [sehd_pkg::WINDOW_DEPTH];
   logic [POS_W-1:0]         pos_ff;
   logic [POS_W-1:0]         pos_in;
   logic [7:0]               sum_ff;
   logic [7:0]               sum_in;
   logic [7:0]               first_ff;
   logic [7:0]               first_in;
   logic [7:0]               cmd_ff;
   logic [7:0]               cmd_in;
   sehd_pkg::sehd_flags_type flags_ff;
   sehd_pkg::sehd_flags_type flags_in;
   logic                     frame_done;
   logic                     in_payload;
   logic [POS_W-1:0]         diff;
   logic [DIFF_W-1:0]        diff_wide;
   logic [7:0]               count;
   sehd_pkg::sehd_status_type status;

   // shift the delay window
   always_comb begin
      win_in[0] = rx_byte;
      for (int i = 1; i < sehd_pkg::WINDOW_DEPTH; i++) begin
         win_in[i] = win_ff[i-1];
      end
   end

   // next frame bookkeeping
   always_comb begin
      first_in = (pos_ff == '0) ? rx_byte : first_ff;
      cmd_in   = (pos_ff == POS_ONE) ? rx_byte : cmd_ff;
      flags_in.stx_seen = flags_ff.stx_seen || (rx_byte == sehd_pkg::BYTE_STX);
      flags_in.etx_seen = flags_ff.etx_seen || (rx_byte == sehd_pkg::BYTE_ETX);
      flags_in.prev_cr  = (rx_byte == sehd_pkg::BYTE_CR);
      flags_in.overflow = flags_ff.overflow || (pos_ff >= POS_MAX);
      sum_in = (pos_ff >= POS_SUM_START) ? sum_ff + win_in[LAST] : sum_ff;
      pos_in = (pos_ff < POS_MAX) ? pos_ff + POS_ONE : POS_MAX;
   end

   assign frame_done = (rx_byte == sehd_pkg::BYTE_LF) && flags_ff.prev_cr;
   assign in_payload = (pos_ff >= POS_PAYLOAD);

   // saturated payload count
   always_comb begin
      diff      = pos_ff - POS_PAYLOAD;
      diff_wide = {8'h00, diff};
      if (!in_payload) begin
         count = 8'h00;
      end else if (diff_wide > DIFF_W'(sehd_pkg::COUNT_MAX)) begin
         count = sehd_pkg::COUNT_MAX;
      end else begin
         count = diff_wide[7:0];
      end
   end

   // end-of-frame status in priority order
   always_comb begin
      if (first_in == sehd_pkg::BYTE_ACK) begin
         status = sehd_pkg::STATUS_ACK;
      end else if (first_in == sehd_pkg::BYTE_NAK) begin
         status = sehd_pkg::STATUS_NAK;
      end else if (flags_in.overflow) begin
         status = sehd_pkg::STATUS_LONG;
      end else if (!flags_in.stx_seen || !flags_in.etx_seen || !in_payload ||
                   win_in[LAST] != sehd_pkg::BYTE_ETX) begin
         status = sehd_pkg::STATUS_INCOMPLETE;
      end else if (first_in != sehd_pkg::BYTE_STX) begin
         status = sehd_pkg::STATUS_HEADER;
      end else if (win_in[LAST-1] != sehd_pkg::hex_char(sum_in[7:4]) ||
                   win_in[LAST-2] != sehd_pkg::hex_char(sum_in[3:0])) begin
         status = sehd_pkg::STATUS_CHECKSUM;
      end else begin
         status = sehd_pkg::STATUS_OK;
      end
   end

   // build the result of this byte
   always_comb begin
      res = '0;
      res_valid = frame_done || in_payload;
      if (frame_done) begin
         res.frame_end     = 1'b1;
         res.command_byte  = cmd_in;
         res.frame_status  = status;
         res.payload_count = count;
      end else begin
         res.payload_byte = win_in[LAST];
      end
   end

   // advance state; clear it at frame end
   always_ff @(posedge clock) begin
      if (reset || (step && frame_done)) begin
         for (int i = 0; i < sehd_pkg::WINDOW_DEPTH; i++) begin
            win_ff[i] <= 8'h00;
         end
         pos_ff   <= '0;
         sum_ff   <= 8'h00;
         first_ff <= 8'h00;
         cmd_ff   <= 8'h00;
         flags_ff <= '0;
      end else if (step) begin
         for (int i = 0; i < sehd_pkg::WINDOW_DEPTH; i++) begin
            win_ff[i] <= win_in[i];
         end
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         first_ff <= first_in;
         cmd_ff   <= cmd_in;
         flags_ff <= flags_in;
      end
   end

   `SEHD_ASSERT(a_pos_bound, pos_ff <= POS_MAX, "frame position beyond limit")
   `SEHD_ASSERT(a_ovf_pos, !flags_ff.overflow || (pos_ff == POS_MAX), "overflow below limit")
   `SEHD_ASSERT_NEXT(a_end_clears, step && frame_done, {pos_ff, flags_ff} == '0, "state kept")
   `SEHD_ASSERT(a_payload_pos, !(step && res_valid && !res.frame_end) || in_payload, "early byte")

endmodule

[src/sehd_out_stage.sv]
// ----------------------------------------------------------------------------
// STX/ETX deframer result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module sehd_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  sehd_pkg::sehd_rsp_type load_data,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sehd_pkg::sehd_rsp_type rsp_data
);

   logic                   valid_ff;
   logic                   valid_in;
   sehd_pkg::sehd_rsp_type data_ff;

   // room for a new result when empty or being drained
   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // capture result payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[src/stx_etx_hex_sum_deframer.sv]
// ----------------------------------------------------------------------------
// STX/ETX deframer with ASCII hex byte-sum checksum
// Streams payload bytes and reports one status transaction per frame.
// ----------------------------------------------------------------------------
//   channel | dir | payload
//   req     | in  | rx_byte
//   rsp     | out | frame_end, payload_byte, command_byte, frame_status,
//           |     | payload_count
//
// One byte per cycle sustained while rsp is ready; a byte waits in the input
// register and its result is loaded into the result register once that has room.
// A byte leaves the input register when the result register is empty or
// drained in the same cycle, so rsp stalls reach req through one stage only.
// Synchronous reset clears the frame state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stx_etx_hex_sum_deframer #(
   parameter int MAX_FRAME = sehd_pkg::MAX_FRAME_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   sehd_stream_if.sink   req,
   sehd_stream_if.source rsp
);

   logic                   held_valid;
   logic [7:0]             held_byte;
   logic                   out_free;
   logic                   advance;
   logic                   res_valid;
   sehd_pkg::sehd_rsp_type res;
   sehd_pkg::sehd_rsp_type rsp_data;

   // move the held byte through the core when the result side has room
   assign advance = held_valid && out_free;

   sehd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req_byte   (req.payload.rx_byte),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   sehd_core #(
      .MAX_FRAME (MAX_FRAME)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (held_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   sehd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && res_valid),
      .load_data (res),
      .out_free  (out_free),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp.payload = rsp_data;

endmodule
